[rtl/rcfb_pkg.sv]
// Shared types, constants and the CRC byte step for the remote command frame builder.
`default_nettype none

package rcfb_pkg;

    // Frame geometry
    localparam int FRAME_LEN = 14;
    localparam int BODY_LEN  = 12;
    localparam int POS_W     = 4;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] BODY_END = POS_W'(BODY_LEN);

    // Configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes
    localparam logic [2:0] REG_DEVICE_ID        = 3'd0;
    localparam logic [2:0] REG_GROUP_NIBBLE     = 3'd1;
    localparam logic [2:0] REG_DEFAULT_ARG2     = 3'd2;
    localparam logic [2:0] REG_ARG2_PAIR_ONLY   = 3'd3;
    localparam logic [2:0] REG_XOR_ONE_MODE     = 3'd4;
    localparam logic [2:0] REG_HEADER_LEAD_BYTE = 3'd5;

    // Register reset values
    localparam logic [7:0] DEFAULT_ARG2_RST     = 8'h83;
    localparam logic [7:0] HEADER_LEAD_BYTE_RST = 8'h77;

    // Command codes
    localparam logic [7:0] CMD_PAIR      = 8'h28;
    localparam logic [7:0] CMD_PASS_ARG2 = 8'h22;
    localparam logic [7:0] CMD_NOARG_A   = 8'h12;
    localparam logic [7:0] CMD_NOARG_B   = 8'h13;
    localparam logic [7:0] CMD_NOARG_C   = 8'h1E;
    localparam logic [7:0] CMD_NOARG_D   = 8'h1F;

    // CRC-16 settings
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT_XOR = 16'hFFFF;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [23:0] device_id;
        logic [3:0]  group_nibble;
        logic [7:0]  default_arg2;
        logic        arg2_pair_only;
        logic        xor_one_mode;
        logic [7:0]  header_lead_byte;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  command_code;
        logic [7:0]  arg_zero;
        logic [7:0]  arg_one;
        logic [7:0]  arg_two;
        logic [7:0]  param_byte;
        logic [7:0]  transmit_count;
        logic [15:0] seed_value;
    } cmd_t;

    // Source of the next frame byte
    typedef enum logic [2:0] {
        SEL_BODY   = 3'b001,
        SEL_CRC_LO = 3'b010,
        SEL_CRC_HI = 3'b100
    } byte_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      advance;
        byte_sel_t byte_sel;
        logic      last;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
    } dp_status_t;

    // One byte of CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input byte_t b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/rcfb_if.sv]
// Command and frame-byte channel interfaces with valid/ready handshake.
`default_nettype none

interface rcfb_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command_code;
    logic [7:0]  arg_zero;
    logic [7:0]  arg_one;
    logic [7:0]  arg_two;
    logic [7:0]  param_byte;
    logic [7:0]  transmit_count;
    logic [15:0] seed_value;

    modport source (
        output valid, command_code, arg_zero, arg_one, arg_two, param_byte,
               transmit_count, seed_value,
        input  ready
    );
    modport sink (
        input  valid, command_code, arg_zero, arg_one, arg_two, param_byte,
               transmit_count, seed_value,
        output ready
    );
endinterface

interface rcfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

`default_nettype wire

[rtl/remote_command_frame_builder_top.sv]
// Top level of the remote command frame builder.
//
//   channel     dir  handshake     payload
//   cmd_in      in   valid/ready   command_code, arg_zero..arg_two, param_byte,
//                                  transmit_count, seed_value
//   frame_out   out  valid/ready   frame_byte, last_byte
//   apb         in   psel/penable  paddr[4:2] selects register, pwdata, prdata
//
// One command yields fourteen byte requests, one per cycle when frame_out is ready:
// the command is accepted first, and then its fourteen byte slots follow.
// A new command is taken once the last byte is loaded into the output register.
// The CRC folds in one body byte per cycle, unless frame_out stalls, as that byte is loaded for output.
// A stall on frame_out holds the output register and the sequencer.
// Reset (rst_n low, asynchronous) empties the output and returns to idle.
`default_nettype none

module remote_command_frame_builder_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rcfb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rcfb_pkg::PDATA_W-1:0] pwdata,
    output      logic [rcfb_pkg::PDATA_W-1:0] prdata,
    output      logic                         pready,
    rcfb_cmd_if.sink                          cmd_in,
    rcfb_frame_if.source                      frame_out
);
    import rcfb_pkg::*;

    cfg_t       cfg;
    cmd_t       cmd_word;
    dp_cmd_t    ctl;
    dp_status_t status;
    logic       in_ready;

    assign cmd_word.command_code   = cmd_in.command_code;
    assign cmd_word.arg_zero       = cmd_in.arg_zero;
    assign cmd_word.arg_one        = cmd_in.arg_one;
    assign cmd_word.arg_two        = cmd_in.arg_two;
    assign cmd_word.param_byte     = cmd_in.param_byte;
    assign cmd_word.transmit_count = cmd_in.transmit_count;
    assign cmd_word.seed_value     = cmd_in.seed_value;
    assign cmd_in.ready            = in_ready;

    rcfb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (ctl)
    );

    rcfb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_in    (cmd_word),
        .ctl       (ctl),
        .status    (status),
        .out_valid (frame_out.valid),
        .out_ready (frame_out.ready),
        .out_byte  (frame_out.frame_byte),
        .out_last  (frame_out.last_byte)
    );

    // A taken command blocks the next one while its bytes go out
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_in.valid && in_ready) |=> !in_ready)
        else $error("command accepted while previous frame still in progress");

    // Never overwrite an output byte that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance |-> (!frame_out.valid || frame_out.ready))
        else $error("output byte overwritten before it was taken");

    // The last marker goes only with the CRC high byte
    a_last_on_crc_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.advance && ctl.last) |-> (ctl.byte_sel == SEL_CRC_HI))
        else $error("last marker on a byte other than the CRC high byte");

    // Loading and emitting never coincide
    a_load_excl_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.advance))
        else $error("load and advance in the same cycle");

endmodule

`default_nettype wire

[rtl/rcfb_regs.sv]
// APB-style configuration register file.
`default_nettype none

module rcfb_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rcfb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rcfb_pkg::PDATA_W-1:0] pwdata,
    output      logic [rcfb_pkg::PDATA_W-1:0] prdata,
    output      logic                         pready,
    output      rcfb_pkg::cfg_t               cfg
);
    import rcfb_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id        <= '0;
            cfg_reg.group_nibble     <= '0;
            cfg_reg.default_arg2     <= DEFAULT_ARG2_RST;
            cfg_reg.arg2_pair_only   <= 1'b0;
            cfg_reg.xor_one_mode     <= 1'b0;
            cfg_reg.header_lead_byte <= HEADER_LEAD_BYTE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEVICE_ID:        cfg_reg.device_id        <= pwdata[23:0];
                REG_GROUP_NIBBLE:     cfg_reg.group_nibble     <= pwdata[3:0];
                REG_DEFAULT_ARG2:     cfg_reg.default_arg2     <= pwdata[7:0];
                REG_ARG2_PAIR_ONLY:   cfg_reg.arg2_pair_only   <= pwdata[0];
                REG_XOR_ONE_MODE:     cfg_reg.xor_one_mode     <= pwdata[0];
                REG_HEADER_LEAD_BYTE: cfg_reg.header_lead_byte <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    // Return the addressed register, zero beyond the list
    always_comb
    begin
        case (reg_idx)
            REG_DEVICE_ID:        prdata = PDATA_W'(cfg_reg.device_id);
            REG_GROUP_NIBBLE:     prdata = PDATA_W'(cfg_reg.group_nibble);
            REG_DEFAULT_ARG2:     prdata = PDATA_W'(cfg_reg.default_arg2);
            REG_ARG2_PAIR_ONLY:   prdata = PDATA_W'(cfg_reg.arg2_pair_only);
            REG_XOR_ONE_MODE:     prdata = PDATA_W'(cfg_reg.xor_one_mode);
            REG_HEADER_LEAD_BYTE: prdata = PDATA_W'(cfg_reg.header_lead_byte);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/rcfb_ctrl.sv]
// Frame sequencer: accepts a command and steps through the fourteen byte slots.
`default_nettype none

module rcfb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire rcfb_pkg::dp_status_t status,
    output      rcfb_pkg::dp_cmd_t    cmd
);
    import rcfb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.load    = in_ready & in_valid;
    assign cmd.advance = (state_reg == ST_EMIT) & status.slot_free;
    assign cmd.last    = (pos_reg == LAST_POS);

    // Pick the byte source from the slot index
    assign cmd.byte_sel = (pos_reg < BODY_END)  ? SEL_BODY   :
                          (pos_reg == BODY_END) ? SEL_CRC_LO : SEL_CRC_HI;

    // Advance the slot index, return to idle after the last byte
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EMIT;
                    pos_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (cmd.advance)
                begin
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pos_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rcfb_datapath.sv]
// Frame body latch, running CRC and the registered output byte.
`default_nettype none

module rcfb_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rcfb_pkg::cfg_t       cfg,
    input  wire rcfb_pkg::cmd_t       cmd_in,
    input  wire rcfb_pkg::dp_cmd_t    ctl,
    output      rcfb_pkg::dp_status_t status,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [7:0]           out_byte,
    output      logic                 out_last
);
    import rcfb_pkg::*;

    byte_t       frame_reg [BODY_LEN];
    byte_t       body [BODY_LEN];
    logic [15:0] crc_reg;
    logic        out_valid_reg, out_valid_next;
    byte_t       out_byte_reg;
    logic        out_last_reg;
    byte_t       next_byte;
    logic        pair;
    byte_t       seed_lo;
    byte_t       id_lo;
    byte_t       id_nib;
    byte_t       arg2_sel;

    assign pair    = (cmd_in.command_code == CMD_PAIR);
    assign seed_lo = cmd_in.seed_value[7:0];
    assign id_lo   = cfg.device_id[7:0];
    assign id_nib  = {cfg.device_id[15:12], 4'h0};

    // Choose arg2 by the injection rules
    always_comb
    begin
        if (cmd_in.command_code == CMD_PASS_ARG2)
            arg2_sel = cmd_in.arg_two;
        else if (pair)
            arg2_sel = cfg.default_arg2;
        else if (!cfg.arg2_pair_only
                 && cmd_in.command_code != CMD_NOARG_A
                 && cmd_in.command_code != CMD_NOARG_B
                 && cmd_in.command_code != CMD_NOARG_C
                 && cmd_in.command_code != CMD_NOARG_D)
            arg2_sel = cfg.default_arg2;
        else
            arg2_sel = 8'h00;
    end

    // Assemble the twelve body bytes
    always_comb
    begin
        body[0]  = cmd_in.command_code;
        body[1]  = id_lo;
        body[2]  = {cfg.device_id[15:12], cfg.group_nibble};
        body[3]  = pair ? id_lo : cmd_in.arg_zero;
        body[4]  = pair ? id_nib : cmd_in.arg_one;
        body[5]  = arg2_sel;
        body[6]  = cmd_in.transmit_count;
        body[7]  = (pair && cfg.default_arg2 == 8'h00) ? cfg.header_lead_byte
                                                        : cmd_in.param_byte;
        body[8]  = cfg.xor_one_mode ? (seed_lo ^ 8'h01) : (seed_lo ^ cfg.device_id[23:16]);
        body[9]  = cfg.xor_one_mode ? (seed_lo ^ 8'h01) : seed_lo;
        body[10] = seed_lo;
        body[11] = cmd_in.seed_value[15:8];
    end

    // Latch the body on load, shift one byte out per slot
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < BODY_LEN; i++)
                frame_reg[i] <= body[i];
        end
        else if (ctl.advance)
        begin
            for (int i = 0; i < BODY_LEN - 1; i++)
                frame_reg[i] <= frame_reg[i+1];
        end
    end

    // Seed the CRC on load, fold in each body byte as it goes out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= '0;
        else if (ctl.load)
            crc_reg <= cmd_in.seed_value ^ CRC_INIT_XOR;
        else if (ctl.advance && ctl.byte_sel == SEL_BODY)
            crc_reg <= crc_byte(crc_reg, frame_reg[0]);
    end

    always_comb
    begin
        case (ctl.byte_sel)
            SEL_BODY:   next_byte = frame_reg[0];
            SEL_CRC_LO: next_byte = crc_reg[7:0];
            SEL_CRC_HI: next_byte = crc_reg[15:8];
            default:    next_byte = frame_reg[0];
        endcase
    end

    // Output slot: fill on advance, empty when the request is taken
    assign status.slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (ctl.advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            out_byte_reg <= next_byte;
            out_last_reg <= ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

[tb/sv/rcfb_tb_pkg.sv]
// Scoreboard class for the remote command frame builder testbench.
package rcfb_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import rcfb_pkg::*;

    // Register slots past the last real register; writes there must be dropped
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam int MAX_REPORTS = 25;

    typedef struct {
        byte_t data;
        logic  last;
    } frame_entry_t;

    class frame_scoreboard;
        cfg_t         cfg;
        frame_entry_t expected_bytes[$];
        int unsigned  mismatches;
        int unsigned  bytes_checked;
        int unsigned  commands_seen;

        function new();
            cfg.device_id        = '0;
            cfg.group_nibble     = '0;
            cfg.default_arg2     = DEFAULT_ARG2_RST;
            cfg.arg2_pair_only   = 1'b0;
            cfg.xor_one_mode     = 1'b0;
            cfg.header_lead_byte = HEADER_LEAD_BYTE_RST;
            mismatches    = 0;
            bytes_checked = 0;
            commands_seen = 0;
        endfunction

        // Mirror a register write, keeping only the implemented bits
        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_DEVICE_ID:        cfg.device_id        = value[23:0];
                REG_GROUP_NIBBLE:     cfg.group_nibble     = value[3:0];
                REG_DEFAULT_ARG2:     cfg.default_arg2     = value[7:0];
                REG_ARG2_PAIR_ONLY:   cfg.arg2_pair_only   = value[0];
                REG_XOR_ONE_MODE:     cfg.xor_one_mode     = value[0];
                REG_HEADER_LEAD_BYTE: cfg.header_lead_byte = value[7:0];
                default: ;
            endcase
        endfunction

        // Shift one byte through the CRC-16 register, one bit at a time
        function logic [15:0] crc_fold(logic [15:0] crc, byte_t b);
            logic [15:0] r;
            logic        feedback;
            r = crc;
            for (int k = 7; k >= 0; k--)
            begin
                feedback = r[15] ^ b[k];
                r = {r[14:0], 1'b0};
                if (feedback)
                    r = r ^ CRC_POLY;
            end
            return r;
        endfunction

        // Build the fourteen frame bytes for one accepted command request
        function void note_command(cmd_t c);
            byte_t       body[BODY_LEN];
            logic        pair;
            logic        no_arg_cmd;
            byte_t       seed_lo;
            byte_t       id_lo;
            byte_t       id_nib;
            byte_t       salt;
            byte_t       arg2;
            logic [15:0] crc;
            frame_entry_t e;

            pair       = (c.command_code == CMD_PAIR);
            no_arg_cmd = (c.command_code == CMD_NOARG_A) || (c.command_code == CMD_NOARG_B) ||
                         (c.command_code == CMD_NOARG_C) || (c.command_code == CMD_NOARG_D);
            seed_lo = c.seed_value[7:0];
            id_lo   = cfg.device_id[7:0];
            id_nib  = {cfg.device_id[15:12], 4'h0};
            salt    = cfg.device_id[23:16];

            // Pick arg2: pass-through, pair injection, or general rule
            if (c.command_code == CMD_PASS_ARG2)
                arg2 = c.arg_two;
            else if (pair)
                arg2 = cfg.default_arg2;
            else if (!cfg.arg2_pair_only && !no_arg_cmd)
                arg2 = cfg.default_arg2;
            else
                arg2 = '0;

            body[0]  = c.command_code;
            body[1]  = id_lo;
            body[2]  = id_nib | {4'h0, cfg.group_nibble};
            body[3]  = pair ? id_lo : c.arg_zero;
            body[4]  = pair ? id_nib : c.arg_one;
            body[5]  = arg2;
            body[6]  = c.transmit_count;
            body[7]  = (pair && cfg.default_arg2 == 8'h00) ? cfg.header_lead_byte : c.param_byte;
            body[8]  = cfg.xor_one_mode ? (seed_lo ^ 8'h01) : (seed_lo ^ salt);
            body[9]  = cfg.xor_one_mode ? (seed_lo ^ 8'h01) : seed_lo;
            body[10] = seed_lo;
            body[11] = c.seed_value[15:8];

            crc = c.seed_value ^ CRC_INIT_XOR;
            for (int i = 0; i < BODY_LEN; i++)
            begin
                e.data = body[i];
                e.last = 1'b0;
                expected_bytes.insert(expected_bytes.size(), e);
                crc = crc_fold(crc, body[i]);
            end
            e.data = crc[7:0];
            e.last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), e);
            e.data = crc[15:8];
            e.last = 1'b1;
            expected_bytes.insert(expected_bytes.size(), e);
            commands_seen++;
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        // Compare one delivered frame byte against the oldest expectation
        task check_byte(byte_t data, logic last);
            frame_entry_t want;
            int unsigned  pos;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last=%0b", data, last));
                return;
            end
            want = expected_bytes.pop_front();
            pos  = bytes_checked % FRAME_LEN;
            bytes_checked++;
            if (data !== want.data)
                report_mismatch($sformatf("byte %0d: got %02h, want %02h", pos, data, want.data));
            if (last !== want.last)
                report_mismatch($sformatf("byte %0d: last got %0b, want %0b", pos, last,
                                          want.last));
        endtask
    endclass

endpackage

[tb/sv/remote_command_frame_builder_top_tb.sv]
// Testbench top: drives command requests and APB writes, checks every frame byte.
module remote_command_frame_builder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rcfb_pkg::*;
    import rcfb_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 44;
    localparam int LONG_HOLD     = 300;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rcfb_cmd_if   cmd_if();
    rcfb_frame_if frame_if();

    frame_scoreboard sb;
    bit              idle_on;
    int unsigned     hold_request;
    int unsigned     cycle_count;
    int unsigned     phases_run;

    remote_command_frame_builder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_in    (cmd_if),
        .frame_out (frame_if)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Frame byte receiver: random stall bursts plus an optional long hold-off
    initial
    begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        frame_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (frame_if.valid && frame_if.ready)
                sb.check_byte(frame_if.frame_byte, frame_if.last_byte);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                frame_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                frame_if.ready <= 1'b0;
            end
            else
                frame_if.ready <= 1'b1;
        end
    end

    function automatic cmd_t command_of(byte_t code, byte_t a0, byte_t a1, byte_t a2,
                                        byte_t prm, byte_t cnt, logic [15:0] seed);
        cmd_t c;
        c.command_code   = code;
        c.arg_zero       = a0;
        c.arg_one        = a1;
        c.arg_two        = a2;
        c.param_byte     = prm;
        c.transmit_count = cnt;
        c.seed_value     = seed;
        return c;
    endfunction

    // Mix of pair, pass-through, no-arg and arbitrary commands with random content
    function automatic cmd_t random_command();
        int unsigned kind;
        byte_t       code;
        kind = $urandom_range(0, 99);
        if (kind < 20)
            code = CMD_PAIR;
        else if (kind < 35)
            code = CMD_PASS_ARG2;
        else if (kind < 55)
        begin
            case ($urandom_range(0, 3))
                0: code = CMD_NOARG_A;
                1: code = CMD_NOARG_B;
                2: code = CMD_NOARG_C;
                default: code = CMD_NOARG_D;
            endcase
        end
        else
            code = byte_t'($urandom_range(0, 255));
        return command_of(code, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                          byte_t'($urandom), byte_t'($urandom), 16'($urandom));
    endfunction

    // Register value: often an extreme, otherwise random with junk in unused bits
    function automatic logic [31:0] random_register_value();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    // Offer one command request and hold it until accepted
    task automatic send_command(cmd_t c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.command_code   <= c.command_code;
        cmd_if.arg_zero       <= c.arg_zero;
        cmd_if.arg_one        <= c.arg_one;
        cmd_if.arg_two        <= c.arg_two;
        cmd_if.param_byte     <= c.param_byte;
        cmd_if.transmit_count <= c.transmit_count;
        cmd_if.seed_value     <= c.seed_value;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        sb.note_command(c);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Wait for every expected byte, then let the pipeline settle
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sb           = new();
        idle_on      = 1'b1;
        hold_request = 0;
        cycle_count  = 0;
        phases_run   = 0;

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        cmd_if.valid          <= 1'b0;
        cmd_if.command_code   <= '0;
        cmd_if.arg_zero       <= '0;
        cmd_if.arg_one        <= '0;
        cmd_if.arg_two        <= '0;
        cmd_if.param_byte     <= '0;
        cmd_if.transmit_count <= '0;
        cmd_if.seed_value     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: every arg2 path, field extremes, seed extremes
        send_command(command_of(CMD_PAIR, 8'h11, 8'h22, 8'h33, 8'h44, 8'h01, 16'h1234));
        send_command(command_of(CMD_PASS_ARG2, 8'h01, 8'h02, 8'hA5, 8'h03, 8'h04, 16'hBEEF));
        send_command(command_of(CMD_NOARG_A, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 16'h00FF));
        send_command(command_of(CMD_NOARG_B, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'h80, 16'hFF00));
        send_command(command_of(CMD_NOARG_C, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 16'h5AA5));
        send_command(command_of(CMD_NOARG_D, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 16'hA55A));
        send_command(command_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_command(command_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_command(command_of(CMD_PAIR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_command(command_of(CMD_PASS_ARG2, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 16'h8001));
        drain();

        // All registers at extremes, junk above the implemented bits, spare slots hit
        write_register(REG_DEVICE_ID, 32'hFFFF_FFFF);
        write_register(REG_GROUP_NIBBLE, 32'hFFFF_FFFF);
        write_register(REG_DEFAULT_ARG2, 32'hFFFF_FF00);
        write_register(REG_ARG2_PAIR_ONLY, 32'hFFFF_FFFF);
        write_register(REG_XOR_ONE_MODE, 32'hFFFF_FFFF);
        write_register(REG_HEADER_LEAD_BYTE, 32'hFFFF_FFFF);
        write_register(REG_SPARE_6, 32'hFFFF_FFFF);
        write_register(REG_SPARE_7, 32'h0000_0000);
        send_command(command_of(CMD_PAIR, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 16'hC3E1));
        send_command(command_of(CMD_PASS_ARG2, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 16'h0001));
        send_command(command_of(CMD_NOARG_A, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 16'hFFFE));
        send_command(command_of(8'h77, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 16'h7F80));
        drain();

        // Opposite corner: zero mode bits, full default arg2, zero header byte
        write_register(REG_DEVICE_ID, 32'h005A_3C96);
        write_register(REG_GROUP_NIBBLE, 32'h0);
        write_register(REG_DEFAULT_ARG2, 32'hFF);
        write_register(REG_ARG2_PAIR_ONLY, 32'h0);
        write_register(REG_XOR_ONE_MODE, 32'h0);
        write_register(REG_HEADER_LEAD_BYTE, 32'h0);
        send_command(command_of(CMD_PAIR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_command(command_of(CMD_NOARG_D, 8'hC0, 8'h0C, 8'hFF, 8'h01, 8'hFE, 16'h4321));
        send_command(command_of(8'h40, 8'hC0, 8'h0C, 8'hFF, 8'h01, 8'hFE, 16'hFFFF));
        drain();
        phases_run = 3;

        // Random phases, each with a fresh configuration
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_register(REG_DEVICE_ID, random_register_value());
            write_register(REG_GROUP_NIBBLE, random_register_value());
            write_register(REG_DEFAULT_ARG2, random_register_value());
            write_register(REG_ARG2_PAIR_ONLY, random_register_value());
            write_register(REG_XOR_ONE_MODE, random_register_value());
            write_register(REG_HEADER_LEAD_BYTE, random_register_value());
            if ($urandom_range(0, 1) == 1)
                write_register(REG_SPARE_6, $urandom);
            // Stall the output long enough to back up the input
            if (p == 1)
                hold_request = LONG_HOLD;
            // No idling on either side in the last phase
            if (p == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_command(random_command());
            drain();
            phases_run++;
        end

        $display("Run covered %0d command requests and %0d frame bytes over %0d settings,",
                 sb.commands_seen, sb.bytes_checked, phases_run);
        $display("including every arg2 rule, both seed-byte modes and a long output hold.");
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
rtl/rcfb_pkg.sv
rtl/rcfb_if.sv
rtl/rcfb_regs.sv
rtl/rcfb_ctrl.sv
rtl/rcfb_datapath.sv
rtl/remote_command_frame_builder_top.sv
tb/sv/rcfb_tb_pkg.sv
tb/sv/remote_command_frame_builder_top_tb.sv
